// ===== src/sgh_pkg.sv =====
// shared constants, types and angle table function for the segment heading pipeline
package sgh_pkg;

   localparam int COORD_BITS      = 32;
   localparam int ANGLE_FRAC_BITS = 16;
   localparam int CORDIC_STAGES   = 24;

   // fixed internal formats
   localparam int DEG_FRAC    = 40;
   localparam int RAD_FRAC    = 60;
   localparam int DIFF_W      = COORD_BITS + 1;
   localparam int CORD_W      = 64;
   localparam int SCALE_SHIFT = RAD_FRAC - COORD_BITS;
   localparam int Z_W         = DEG_FRAC + 8;
   localparam int TH_W        = DEG_FRAC + 7;
   localparam int FULL_W      = DEG_FRAC + 9;
   localparam int HEADING_W   = 25;
   localparam int ROUND_SH    = DEG_FRAC - ANGLE_FRAC_BITS;
   localparam int H_W         = FULL_W + 1 - ROUND_SH;

   localparam logic [127:0] QUARTER_PI_RAD = 128'h0C90FDAA22168C23;

   localparam logic [TH_W-1:0]   DEG_90       = TH_W'(90) << DEG_FRAC;
   localparam logic [FULL_W-1:0] DEG_180      = FULL_W'(180) << DEG_FRAC;
   localparam logic [FULL_W-1:0] DEG_360      = FULL_W'(360) << DEG_FRAC;
   localparam logic [FULL_W:0]   ROUND_HALF   = (FULL_W + 1)'(1) << (ROUND_SH - 1);
   localparam logic [H_W-1:0]    HEADING_WRAP = H_W'(360) << ANGLE_FRAC_BITS;

   // quadrant codes, {x negative, y negative}
   localparam logic [1:0] QUAD_FIRST  = 2'b00;
   localparam logic [1:0] QUAD_SECOND = 2'b10;
   localparam logic [1:0] QUAD_THIRD  = 2'b11;
   localparam logic [1:0] QUAD_FOURTH = 2'b01;

   typedef struct packed {
      logic degenerate;
      logic ax_zero;
      logic ay_zero;
      logic neg_x;
      logic neg_y;
   } tag_type;

   // restoring long division, evaluated at elaboration only
   function automatic logic [127:0] udiv_wide(input logic [127:0] num,
                                              input logic [127:0] den);
      logic [127:0] rem;
      logic [127:0] q;
      rem = '0;
      q   = '0;
      for (int b = 127; b >= 0; b--) begin
         rem = {rem[126:0], num[b]};
         if (rem >= den) begin
            rem  = rem - den;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // atan(2^-i) in degrees with DEG_FRAC fractional bits
   function automatic logic [Z_W-1:0] atan_deg(input int i);
      logic [127:0] rad;
      logic [127:0] term;
      logic [127:0] num;
      int           m;
      if (i == 0) begin
         rad = QUARTER_PI_RAD;
      end else begin
         rad = '0;
         for (int k = 0; k <= RAD_FRAC; k++) begin
            m = i * (2 * k + 1);
            if (m <= RAD_FRAC) begin
               term = udiv_wide(128'(1) << (RAD_FRAC - m), 128'(2 * k + 1));
               if (k[0]) begin
                  rad = rad - term;
               end else begin
                  rad = rad + term;
               end
            end
         end
      end
      num = rad * (128'(45) << DEG_FRAC) + (QUARTER_PI_RAD >> 1);
      return Z_W'(udiv_wide(num, QUARTER_PI_RAD));
   endfunction

endpackage

// ===== src/sgh_front.sv =====
// input skid stage, coordinate differences and first-quadrant fold
module sgh_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [sgh_pkg::COORD_BITS-1:0] req_end_x,
   input  logic signed [sgh_pkg::COORD_BITS-1:0] req_end_y,
   input  logic signed [sgh_pkg::COORD_BITS-1:0] req_start_x,
   input  logic signed [sgh_pkg::COORD_BITS-1:0] req_start_y,
   output logic                                 valid_o,
   output logic signed [sgh_pkg::CORD_W-1:0]     x_o,
   output logic signed [sgh_pkg::CORD_W-1:0]     y_o,
   output sgh_pkg::tag_type                      tag_o
);
   import sgh_pkg::*;

   logic                         skid_valid_ff, skid_valid_in;
   logic signed [COORD_BITS-1:0] skid_end_x_ff, skid_end_y_ff;
   logic signed [COORD_BITS-1:0] skid_start_x_ff, skid_start_y_ff;
   logic                         accept;
   logic                         sel_valid;
   logic signed [COORD_BITS-1:0] sel_end_x, sel_end_y, sel_start_x, sel_start_y;

   logic                     v1_ff;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff, dx_in, dy_in;

   logic                     v2_ff;
   logic signed [CORD_W-1:0] x_ff, y_ff, x_in, y_in;
   tag_type                  tag_ff, tag_in;
   logic [COORD_BITS-1:0]    ax_in, ay_in;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid & ~skid_valid_ff;

   // skid register catches a transfer taken while the pipeline is frozen
   always_comb begin
      skid_valid_in = skid_valid_ff;
      if (advance) begin
         skid_valid_in = 1'b0;
      end else if (accept) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept & ~advance) begin
         skid_end_x_ff   <= req_end_x;
         skid_end_y_ff   <= req_end_y;
         skid_start_x_ff <= req_start_x;
         skid_start_y_ff <= req_start_y;
      end
   end

   assign sel_valid   = skid_valid_ff | req_valid;
   assign sel_end_x   = skid_valid_ff ? skid_end_x_ff   : req_end_x;
   assign sel_end_y   = skid_valid_ff ? skid_end_y_ff   : req_end_y;
   assign sel_start_x = skid_valid_ff ? skid_start_x_ff : req_start_x;
   assign sel_start_y = skid_valid_ff ? skid_start_y_ff : req_start_y;

   assign dx_in = DIFF_W'(sel_end_x) - DIFF_W'(sel_start_x);
   assign dy_in = DIFF_W'(sel_end_y) - DIFF_W'(sel_start_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= sel_valid;
         v2_ff <= v1_ff;
      end
   end

   // fold into the first quadrant and scale up to the cordic format
   always_comb begin
      tag_in.neg_x      = dx_ff[DIFF_W-1];
      tag_in.neg_y      = dy_ff[DIFF_W-1];
      tag_in.ax_zero    = (dx_ff == '0);
      tag_in.ay_zero    = (dy_ff == '0);
      tag_in.degenerate = tag_in.ax_zero & tag_in.ay_zero;
      ax_in = COORD_BITS'(tag_in.neg_x ? -dx_ff : dx_ff);
      ay_in = COORD_BITS'(tag_in.neg_y ? -dy_ff : dy_ff);
      x_in  = CORD_W'(ax_in) << SCALE_SHIFT;
      y_in  = CORD_W'(ay_in) << SCALE_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         x_ff   <= x_in;
         y_ff   <= y_in;
         tag_ff <= tag_in;
      end
   end

   assign valid_o = v2_ff;
   assign x_o     = x_ff;
   assign y_o     = y_ff;
   assign tag_o   = tag_ff;

endmodule

// ===== src/sgh_cordic.sv =====
// unrolled vectoring cordic, one micro-rotation per register stage
module sgh_cordic (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              valid_i,
   input  logic signed [sgh_pkg::CORD_W-1:0] x_i,
   input  logic signed [sgh_pkg::CORD_W-1:0] y_i,
   input  sgh_pkg::tag_type                  tag_i,
   output logic                              valid_o,
   output logic signed [sgh_pkg::Z_W-1:0]    z_o,
   output sgh_pkg::tag_type                  tag_o
);
   import sgh_pkg::*;

   logic signed [CORD_W-1:0] xs [CORDIC_STAGES];
   logic signed [CORD_W-1:0] ys [CORDIC_STAGES];
   logic signed [Z_W-1:0]    zs [CORDIC_STAGES+1];
   logic                     vs [CORDIC_STAGES+1];
   tag_type                  tags [CORDIC_STAGES+1];

   logic signed [CORD_W-1:0] x_ff [CORDIC_STAGES-1];
   logic signed [CORD_W-1:0] y_ff [CORDIC_STAGES-1];
   logic signed [Z_W-1:0]    z_ff [CORDIC_STAGES];
   logic                     v_ff [CORDIC_STAGES];
   tag_type                  tag_ff [CORDIC_STAGES];

   assign xs[0]   = x_i;
   assign ys[0]   = y_i;
   assign zs[0]   = '0;
   assign vs[0]   = valid_i;
   assign tags[0] = tag_i;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      localparam logic signed [Z_W-1:0] STEP = atan_deg(i);
      logic                  rot_down;
      logic signed [Z_W-1:0] z_in;

      // rotate clockwise while y is strictly positive
      assign rot_down = ~ys[i][CORD_W-1] & (ys[i] != '0);
      assign z_in     = rot_down ? zs[i] + STEP : zs[i] - STEP;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (advance) begin
            v_ff[i] <= vs[i];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            z_ff[i]   <= z_in;
            tag_ff[i] <= tags[i];
         end
      end

      // the last stage only needs the angle
      if (i < CORDIC_STAGES - 1) begin : g_xy
         logic signed [CORD_W-1:0] x_in, y_in;
         assign x_in = rot_down ? xs[i] + (ys[i] >>> i) : xs[i] - (ys[i] >>> i);
         assign y_in = rot_down ? ys[i] - (xs[i] >>> i) : ys[i] + (xs[i] >>> i);
         always_ff @(posedge clock) begin
            if (advance) begin
               x_ff[i] <= x_in;
               y_ff[i] <= y_in;
            end
         end
         assign xs[i+1] = x_ff[i];
         assign ys[i+1] = y_ff[i];
      end

      assign zs[i+1]   = z_ff[i];
      assign vs[i+1]   = v_ff[i];
      assign tags[i+1] = tag_ff[i];
   end

   assign valid_o = vs[CORDIC_STAGES];
   assign z_o     = zs[CORDIC_STAGES];
   assign tag_o   = tags[CORDIC_STAGES];

endmodule

// ===== src/sgh_back.sv =====
// clamp, axis overrides, quadrant unfold and rounding to the output format
module sgh_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 valid_i,
   input  logic signed [sgh_pkg::Z_W-1:0]       z_i,
   input  sgh_pkg::tag_type                     tag_i,
   output logic                                 valid_o,
   output logic [sgh_pkg::HEADING_W-1:0]        heading_o,
   output logic                                 degenerate_o
);
   import sgh_pkg::*;

   logic              v1_ff, v2_ff, v3_ff;
   logic [TH_W-1:0]   th_ff, th_in;
   tag_type           tag1_ff, tag2_ff;
   logic [FULL_W-1:0] full_ff, full_in;
   logic [FULL_W:0]   rounded;
   logic [H_W-1:0]    h_trunc;
   logic [HEADING_W-1:0] heading_ff, heading_in;
   logic              degenerate_ff;

   // clamp to [0, 90] and force the exact axis directions
   always_comb begin
      if (tag_i.ay_zero) begin
         th_in = '0;
      end else if (tag_i.ax_zero) begin
         th_in = DEG_90;
      end else if (z_i[Z_W-1]) begin
         th_in = '0;
      end else if (z_i > $signed(Z_W'(DEG_90))) begin
         th_in = DEG_90;
      end else begin
         th_in = TH_W'(z_i);
      end
   end

   always_comb begin
      case ({tag1_ff.neg_x, tag1_ff.neg_y})
         QUAD_FIRST:  full_in = FULL_W'(th_ff);
         QUAD_SECOND: full_in = DEG_180 - FULL_W'(th_ff);
         QUAD_THIRD:  full_in = DEG_180 + FULL_W'(th_ff);
         QUAD_FOURTH: full_in = DEG_360 - FULL_W'(th_ff);
         default:     full_in = '0;
      endcase
   end

   // round half up, a result of 360 wraps to 0
   assign rounded = {1'b0, full_ff} + ROUND_HALF;
   assign h_trunc = rounded[FULL_W:ROUND_SH];

   always_comb begin
      if (tag2_ff.degenerate || (h_trunc >= HEADING_WRAP)) begin
         heading_in = '0;
      end else begin
         heading_in = HEADING_W'(h_trunc);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= valid_i;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         th_ff         <= th_in;
         tag1_ff       <= tag_i;
         full_ff       <= full_in;
         tag2_ff       <= tag1_ff;
         heading_ff    <= heading_in;
         degenerate_ff <= tag2_ff.degenerate;
      end
   end

   assign valid_o      = v3_ff;
   assign heading_o    = heading_ff;
   assign degenerate_o = degenerate_ff;

endmodule

// ===== src/segment_heading_degrees.sv =====
// segment heading top level: skid input, cordic angle pipeline, registered output
//
//   channel  | ports                                                           | dir
//   ---------+-----------------------------------------------------------------+----
//   request  | req_valid req_stall req_end_x req_end_y req_start_x req_start_y | in
//   response | rsp_valid rsp_stall rsp_heading rsp_degenerate                  | out
//
// one segment per cycle while the response is not stalled; the pipeline holds two front stages,
// one stage per cordic micro-rotation and three finishing stages.
// synchronous active-high reset clears all valid bits and the skid register.
// a stalled response freezes the whole pipeline; the skid register still takes
// one more request transfer, and req_stall is driven from a register.
module segment_heading_degrees (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [sgh_pkg::COORD_BITS-1:0] req_end_x,
   input  logic signed [sgh_pkg::COORD_BITS-1:0] req_end_y,
   input  logic signed [sgh_pkg::COORD_BITS-1:0] req_start_x,
   input  logic signed [sgh_pkg::COORD_BITS-1:0] req_start_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [sgh_pkg::HEADING_W-1:0]        rsp_heading,
   output logic                                 rsp_degenerate
);
   import sgh_pkg::*;

   logic                     advance;
   logic                     front_valid;
   logic signed [CORD_W-1:0] front_x, front_y;
   tag_type                  front_tag;
   logic                     cordic_valid;
   logic signed [Z_W-1:0]    cordic_z;
   tag_type                  cordic_tag;

   assign advance = ~rsp_valid | ~rsp_stall;

   sgh_front u_front (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_end_x   (req_end_x),
      .req_end_y   (req_end_y),
      .req_start_x (req_start_x),
      .req_start_y (req_start_y),
      .valid_o     (front_valid),
      .x_o         (front_x),
      .y_o         (front_y),
      .tag_o       (front_tag)
   );

   sgh_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .valid_i (front_valid),
      .x_i     (front_x),
      .y_i     (front_y),
      .tag_i   (front_tag),
      .valid_o (cordic_valid),
      .z_o     (cordic_z),
      .tag_o   (cordic_tag)
   );

   sgh_back u_back (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .valid_i      (cordic_valid),
      .z_i          (cordic_z),
      .tag_i        (cordic_tag),
      .valid_o      (rsp_valid),
      .heading_o    (rsp_heading),
      .degenerate_o (rsp_degenerate)
   );

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_heading == '0)
      else $error("degenerate segment with nonzero heading");

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> H_W'(rsp_heading) < HEADING_WRAP)
      else $error("heading at or above 360 degrees");

   a_skid_loads_on_freeze: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(!advance && req_valid))
      else $error("skid register filled while the pipeline was moving");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      req_stall && advance |=> !req_stall)
      else $error("skid register not drained on advance");

endmodule
